FILE: rtl/hpt_pkg.sv
// Shared types and constants of the hashed prefix table.
`default_nettype none
package hpt_pkg;

  localparam int unsigned HalfW   = 64;
  localparam int unsigned KeyW    = 128;
  localparam int unsigned LenW    = 8;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;

  localparam logic [LenW-1:0] MaxLenV4 = 8'd32;
  localparam logic [LenW-1:0] MaxLenV6 = 8'd128;

  typedef enum logic [OpW-1:0] {
    OP_FIND   = 2'd0,
    OP_INSERT = 2'd1,
    OP_ROUTE  = 2'd2,
    OP_SPARE  = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_BAD_LEN = 2'd2,
    ST_SPARE   = 2'd3
  } status_e;

  typedef struct packed {
    logic                hit;
    logic                created;
    logic [IndexW-1:0]   entry_index;
    logic [LenW-1:0]     matched_length;
    logic [StatusW-1:0]  status;
  } rsp_t;

endpackage
`default_nettype wire

FILE: rtl/hpt_req_if.sv
// Request channel carrying one table operation.
`default_nettype none
interface hpt_req_if;
  logic                        valid;
  logic                        ready;
  logic [hpt_pkg::OpW-1:0]     opcode;
  logic [hpt_pkg::HalfW-1:0]   prefix_upper;
  logic [hpt_pkg::HalfW-1:0]   prefix_lower;
  logic [hpt_pkg::LenW-1:0]    prefix_length;

  modport source (output valid, opcode, prefix_upper, prefix_lower, prefix_length,
                  input ready);
  modport sink   (input valid, opcode, prefix_upper, prefix_lower, prefix_length,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/hpt_rsp_if.sv
// Response channel carrying one operation result.
`default_nettype none
interface hpt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          created;
  logic [hpt_pkg::IndexW-1:0]    entry_index;
  logic [hpt_pkg::LenW-1:0]      matched_length;
  logic [hpt_pkg::StatusW-1:0]   status;

  modport source (output valid, hit, created, entry_index, matched_length, status,
                  input ready);
  modport sink   (input valid, hit, created, entry_index, matched_length, status,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/hpt_hash.sv
// Bucket hash: an XOR fold of key and length into BUCKET_BITS bits.
`default_nettype none
module hpt_hash #(
  parameter int unsigned BUCKET_BITS = 8
) (
  input  wire logic [hpt_pkg::KeyW-1:0] key_i,
  input  wire logic [hpt_pkg::LenW-1:0] len_i,
  output      logic [BUCKET_BITS-1:0]   hash_o
);

  localparam int unsigned FoldW = hpt_pkg::KeyW + hpt_pkg::LenW;

  logic [FoldW-1:0] word;

  assign word = {len_i, key_i};

  always_comb begin
    hash_o = '0;
    for (int unsigned i = 0; i < FoldW; i++) begin
      hash_o[i % BUCKET_BITS] = hash_o[i % BUCKET_BITS] ^ word[i];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/hashed_prefix_table_lpm_core.sv
// Top level of the hashed prefix table with longest-prefix match.
`default_nettype none
// The core keeps a chained hash table of address prefixes (address plus length) and
// serves one request at a time: exact find, find-or-insert, or route (longest-prefix
// match). After reset the core sweeps the bucket heads to empty, one bucket per cycle,
// so it accepts no request until the sweep is done; configuration writes are taken
// meanwhile. A request then hashes its prefix and reads its bucket head, reads the
// chain entries one by one, and settles a miss in a state of its own; a route repeats
// that for each prefix length it tries, down to length zero. The single entry memory
// read port feeds one key comparator, so a lookup compares the entries of a chain
// one at a time. The request channel is ready only while the core is idle and the
// previous response has been taken. New entries are linked at the head of their chain;
// since keys are unique, lookups give the same entry wherever it sits in its chain.
module hashed_prefix_table_lpm_core #(
  parameter int unsigned ENTRY_COUNT = 1024,
  parameter int unsigned BUCKET_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic cfg_we_i,
  input  wire logic cfg_wdata_i,
  hpt_req_if.sink   req_i,
  hpt_rsp_if.source rsp_o
);

  // Entry pointers need one more code than entries: the value ENTRY_COUNT ends a chain.
  localparam int unsigned PtrW     = $clog2(ENTRY_COUNT + 1);
  localparam int unsigned AddrW    = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
  localparam int unsigned Buckets  = 1 << BUCKET_BITS;
  localparam int unsigned EntW     = hpt_pkg::KeyW + hpt_pkg::LenW + PtrW;
  localparam logic [PtrW-1:0] Nil  = PtrW'(ENTRY_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_MISS  = 3'd5;

  logic [2:0]                  state_q, state_d;
  logic                        fam_q;
  logic [BUCKET_BITS-1:0]      clr_q, clr_d;
  logic [PtrW-1:0]             count_q, count_d;
  hpt_pkg::op_e                op_q, op_d;
  logic [hpt_pkg::KeyW-1:0]    key_q, key_d;
  logic [hpt_pkg::LenW-1:0]    len_q, len_d;
  logic [BUCKET_BITS-1:0]      hash_q, hash_d;
  logic [PtrW-1:0]             head_q, head_d;
  logic [PtrW-1:0]             cur_q, cur_d;
  logic                        rsp_valid_q, rsp_valid_d;
  hpt_pkg::rsp_t               rsp_q, rsp_d;

  logic [BUCKET_BITS-1:0]      hash_w;

  // Bucket head memory.
  logic [PtrW-1:0]             bucket_mem [Buckets];
  logic                        bkt_we;
  logic [BUCKET_BITS-1:0]      bkt_waddr;
  logic [PtrW-1:0]             bkt_wdata;
  logic                        bkt_re;
  logic [PtrW-1:0]             bkt_rdata_q;

  // Entry memory: key, length and next pointer of each entry.
  logic [EntW-1:0]             entry_mem [ENTRY_COUNT];
  logic                        ent_we;
  logic [AddrW-1:0]            ent_waddr;
  logic [EntW-1:0]             ent_wdata;
  logic                        ent_re;
  logic [PtrW-1:0]             ent_raddr;
  logic [EntW-1:0]             ent_rdata_q;

  logic [hpt_pkg::KeyW-1:0]    ent_key;
  logic [hpt_pkg::LenW-1:0]    ent_len;
  logic [PtrW-1:0]             ent_next;

  logic                        req_fire;
  logic [hpt_pkg::KeyW-1:0]    in_key;
  logic                        in_bad_len;
  logic [hpt_pkg::LenW-1:0]    len_dec;
  logic [6:0]                  bit_pos;

  hpt_hash #(.BUCKET_BITS(BUCKET_BITS)) u_hash (
    .key_i  (key_q),
    .len_i  (len_q),
    .hash_o (hash_w)
  );

  assign {ent_key, ent_len, ent_next} = ent_rdata_q;

  assign req_i.ready = (state_q == S_IDLE) && !rsp_valid_q;
  assign req_fire    = req_i.valid && req_i.ready;

  // IPv4 requests ignore the low address bits entirely.
  assign in_key = fam_q ? {req_i.prefix_upper, req_i.prefix_lower}
                        : {req_i.prefix_upper[63:32], 96'd0};
  assign in_bad_len = req_i.prefix_length >
                      (fam_q ? hpt_pkg::MaxLenV6 : hpt_pkg::MaxLenV4);

  assign len_dec = len_q - 8'd1;
  assign bit_pos = 7'd127 - len_dec[6:0];

  function automatic hpt_pkg::rsp_t make_rsp(logic hit, logic created, logic [PtrW-1:0] idx,
                                             logic [hpt_pkg::LenW-1:0] mlen,
                                             hpt_pkg::status_e st);
    hpt_pkg::rsp_t r;
    logic [31:0]   wide_idx;
    wide_idx         = 32'(idx);
    r.hit            = hit;
    r.created        = created;
    r.entry_index    = wide_idx[hpt_pkg::IndexW-1:0];
    r.matched_length = mlen;
    r.status         = st;
    return r;
  endfunction

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    op_d        = op_q;
    key_d       = key_q;
    len_d       = len_q;
    hash_d      = hash_q;
    head_d      = head_q;
    cur_d       = cur_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    rsp_d       = rsp_q;
    bkt_we      = 1'b0;
    bkt_waddr   = hash_q;
    bkt_wdata   = Nil;
    bkt_re      = 1'b0;
    ent_we      = 1'b0;
    ent_waddr   = count_q[AddrW-1:0];
    ent_wdata   = {key_q, len_q, head_q};
    ent_re      = 1'b0;
    ent_raddr   = bkt_rdata_q;

    case (state_q)
      S_CLEAR: begin
        bkt_we    = 1'b1;
        bkt_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_fire) begin
          op_d  = hpt_pkg::op_e'(req_i.opcode);
          key_d = in_key;
          len_d = req_i.prefix_length;
          if (in_bad_len) begin
            rsp_valid_d = 1'b1;
            rsp_d = make_rsp(1'b0, 1'b0, '0, '0, hpt_pkg::ST_BAD_LEN);
          end else begin
            state_d = S_HASH;
          end
        end
      end
      S_HASH: begin
        bkt_re  = 1'b1;
        hash_d  = hash_w;
        state_d = S_HEAD;
      end
      S_HEAD: begin
        head_d = bkt_rdata_q;
        cur_d  = bkt_rdata_q;
        if (bkt_rdata_q == Nil) begin
          state_d = S_MISS;
        end else begin
          ent_re  = 1'b1;
          state_d = S_WALK;
        end
      end
      S_WALK: begin
        if (ent_key == key_q && ent_len == len_q) begin
          rsp_valid_d = 1'b1;
          rsp_d   = make_rsp(1'b1, 1'b0, cur_q, len_q, hpt_pkg::ST_OK);
          state_d = S_IDLE;
        end else begin
          cur_d = ent_next;
          if (ent_next == Nil) begin
            state_d = S_MISS;
          end else begin
            ent_re    = 1'b1;
            ent_raddr = ent_next;
          end
        end
      end
      S_MISS: begin
        state_d = S_IDLE;
        case (op_q)
          hpt_pkg::OP_INSERT: begin
            rsp_valid_d = 1'b1;
            if (count_q == Nil) begin
              rsp_d = make_rsp(1'b0, 1'b0, '0, '0, hpt_pkg::ST_FULL);
            end else begin
              // Link the new entry in front of the old chain head.
              ent_we    = 1'b1;
              bkt_we    = 1'b1;
              bkt_wdata = count_q;
              count_d   = count_q + 1'b1;
              rsp_d     = make_rsp(1'b1, 1'b1, count_q, len_q, hpt_pkg::ST_OK);
            end
          end
          hpt_pkg::OP_ROUTE: begin
            if (len_q == '0) begin
              rsp_valid_d = 1'b1;
              rsp_d = make_rsp(1'b0, 1'b0, '0, '0, hpt_pkg::ST_OK);
            end else begin
              // Shorten the prefix by one and clear the bit that fell out of it.
              len_d   = len_dec;
              key_d   = key_q & ~(128'd1 << bit_pos);
              state_d = S_HASH;
            end
          end
          default: begin
            rsp_valid_d = 1'b1;
            rsp_d = make_rsp(1'b0, 1'b0, '0, '0, hpt_pkg::ST_OK);
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      fam_q       <= 1'b1;
      clr_q       <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) begin
        fam_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    len_q  <= len_d;
    hash_q <= hash_d;
    head_q <= head_d;
    cur_q  <= cur_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bucket_mem[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rdata_q <= bucket_mem[hash_w];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      entry_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata_q <= entry_mem[ent_raddr[AddrW-1:0]];
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.hit            = rsp_q.hit;
  assign rsp_o.created        = rsp_q.created;
  assign rsp_o.entry_index    = rsp_q.entry_index;
  assign rsp_o.matched_length = rsp_q.matched_length;
  assign rsp_o.status         = rsp_q.status;

endmodule
`default_nettype wire
